// File: rtl/core/linear_probe_hash_table_assert.svh
// Assertion macros for the hash table
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the next cycle
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg
// Types and codes shared by the hash table modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam int IDX_W = 10;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_DUP     = 2'd2;
    localparam logic [1:0] RES_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] found_value;
        logic [CNT_W-1:0]        probe_misses;
        logic [IDX_W-1:0]        slot_index;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch item, start modulo
        logic div_step;  // one remainder bit
        logic fix_home;  // finish home slot
        logic rd;        // read slot at probe pointer
        logic advance;   // step probe pointer
        logic wr_ins;    // write inserted slot
        logic wr_tomb;   // tombstone the slot
        logic finish;    // drive result
        logic [1:0] status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic       clearing;      // slot states being cleared after reset
        logic       div_done;
        logic [1:0] func;
        logic       is_full_now;   // record count >= buckets
        logic [1:0] slot_st;
        logic       key_match;
        logic       probes_out;    // misses + 1 reaches buckets
    } sts_t;

endpackage

// File: rtl/core/lpht_ctrl.sv
// ---------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: modulo, home slot, probe walk, write-back and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_table_assert.svh"

module lpht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lpht_pkg::sts_t    sts,
    output lpht_pkg::ctl_t    ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= lpht_pkg::RES_MISSING;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || sts.clearing;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        ctl         = '0;
        ctl.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !sts.clearing)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_HOME;
            end
            S_HOME:
            begin
                ctl.fix_home = 1'b1;
                if (sts.func == lpht_pkg::FUNC_INSERT && sts.is_full_now)
                begin
                    status_next = lpht_pkg::RES_FULL;
                    state_next  = S_DONE;
                end
                else if (sts.func == lpht_pkg::FUNC_INSERT ||
                         sts.func == lpht_pkg::FUNC_QUERY ||
                         sts.func == lpht_pkg::FUNC_REMOVE)
                    state_next = S_READ;
                else
                begin
                    status_next = lpht_pkg::RES_MISSING;
                    state_next  = S_DONE;
                end
            end
            S_READ:
            begin
                ctl.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if (sts.func == lpht_pkg::FUNC_INSERT)
                begin
                    if (sts.slot_st != lpht_pkg::ST_FULL)
                    begin
                        ctl.wr_ins  = 1'b1;
                        status_next = lpht_pkg::RES_OK;
                    end
                    else if (sts.key_match)
                        status_next = lpht_pkg::RES_DUP;
                    else if (sts.probes_out)
                    begin
                        ctl.advance = 1'b1;
                        status_next = lpht_pkg::RES_FULL;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else
                begin
                    if (sts.slot_st == lpht_pkg::ST_FULL && sts.key_match)
                    begin
                        ctl.wr_tomb = (sts.func == lpht_pkg::FUNC_REMOVE);
                        status_next = lpht_pkg::RES_OK;
                    end
                    else if (sts.slot_st == lpht_pkg::ST_EMPTY)
                        status_next = lpht_pkg::RES_MISSING;
                    else if (sts.probes_out)
                    begin
                        ctl.advance = 1'b1;
                        status_next = lpht_pkg::RES_MISSING;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `LPHT_ASSERT_IMP(a_load_idle, clk, rst_n, ctl.load, state_reg == S_IDLE, "load while busy")
    `LPHT_ASSERT_NEXT(a_done_idle, clk, rst_n, ctl.finish, !busy, "no return to idle")
    `LPHT_ASSERT_IMP(a_one_write, clk, rst_n, ctl.wr_ins, !ctl.wr_tomb && !ctl.advance, "write clash")
    `LPHT_ASSERT_NEXT(a_load_div, clk, rst_n, ctl.load, state_reg == S_DIV, "load not followed by modulo")

endmodule

// File: rtl/core/lpht_dpath.sv
// ---------------------------------------------------------------------------
// lpht_dpath
// Slot memories, serial modulo, probe pointer, counters and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]    cfg_wdata,
    input  lpht_pkg::cmd_t                cmd,
    input  lpht_pkg::ctl_t                ctl,
    output lpht_pkg::sts_t                sts,
    output logic                          result_valid,
    output lpht_pkg::rsp_t                result
);

    localparam int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = lpht_pkg::CNT_W;
    localparam int KW  = lpht_pkg::KEY_W;
    localparam int DW  = CW + 1;          // remainder width
    localparam int BCW = $clog2(KW + 1);

    logic [CW-1:0] bucket_cfg_reg;
    logic [CW-1:0] buckets;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_cfg_reg <= CW'(1021);
        else if (cfg_we)
            bucket_cfg_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (bucket_cfg_reg == '0)
            buckets = CW'(1);
        else if (32'(bucket_cfg_reg) > 32'(TABLE_DEPTH))
            buckets = CW'(TABLE_DEPTH);
        else
            buckets = bucket_cfg_reg;
    end

    // item
    logic [1:0]    func_reg;
    logic [KW-1:0] key_reg;
    logic [lpht_pkg::VAL_W-1:0] val_reg;
    logic          neg_reg;
    logic [KW-1:0] mag_reg;
    logic [DW-1:0] rem_reg;
    logic [BCW-1:0] bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg <= cmd.func;
            key_reg  <= cmd.key;
            val_reg  <= cmd.value;
            neg_reg  <= cmd.key[KW-1];
            mag_reg  <= cmd.key[KW-1] ? (~cmd.key + KW'(1)) : cmd.key;
            rem_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            logic [DW-1:0] t;
            t = {rem_reg[DW-2:0], mag_reg[KW-1]};
            if (t >= DW'(buckets))
                t = t - DW'(buckets);
            rem_reg <= t;
            mag_reg <= {mag_reg[KW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= '0;
        else if (ctl.load)
            bit_reg <= '0;
        else if (ctl.div_step)
            bit_reg <= bit_reg + BCW'(1);
    end

    // probe pointer and miss count
    logic [AW-1:0] ptr_reg;
    logic [CW-1:0] miss_reg;
    logic [AW-1:0] ptr_inc;
    assign ptr_inc = ptr_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (ctl.fix_home)
        begin
            if (neg_reg && rem_reg != '0)
                ptr_reg <= AW'(DW'(buckets) - rem_reg);
            else
                ptr_reg <= AW'(rem_reg);
            miss_reg <= '0;
        end
        else if (ctl.advance)
        begin
            ptr_reg  <= (32'(ptr_reg) + 32'd1 == 32'(buckets)) ? '0 : ptr_inc;
            miss_reg <= miss_reg + CW'(1);
        end
    end

    // slot states cleared entry by entry, in address order, after reset
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                clr_reg <= 1'b0;
        end
    end

    logic [1:0]    st_mem [TABLE_DEPTH];
    logic [KW-1:0] key_mem [TABLE_DEPTH];
    logic [lpht_pkg::VAL_W-1:0] val_mem [TABLE_DEPTH];
    logic [1:0]    st_rd_reg;
    logic [KW-1:0] key_rd_reg;
    logic [lpht_pkg::VAL_W-1:0] val_rd_reg;

    always_ff @(posedge clk)
    begin
        if (clr_reg)
            st_mem[clr_addr_reg] <= lpht_pkg::ST_EMPTY;
        else if (ctl.wr_ins)
            st_mem[ptr_reg] <= lpht_pkg::ST_FULL;
        else if (ctl.wr_tomb)
            st_mem[ptr_reg] <= lpht_pkg::ST_TOMB;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_ins)
        begin
            key_mem[ptr_reg] <= key_reg;
            val_mem[ptr_reg] <= val_reg;
        end
        if (ctl.rd)
        begin
            st_rd_reg  <= st_mem[ptr_reg];
            key_rd_reg <= key_mem[ptr_reg];
            val_rd_reg <= val_mem[ptr_reg];
        end
    end

    logic [CW-1:0] rec_cnt_reg, tomb_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_cnt_reg  <= '0;
            tomb_cnt_reg <= '0;
        end
        else if (ctl.wr_ins)
        begin
            rec_cnt_reg <= rec_cnt_reg + CW'(1);
            if (st_rd_reg == lpht_pkg::ST_TOMB)
                tomb_cnt_reg <= tomb_cnt_reg - CW'(1);
        end
        else if (ctl.wr_tomb)
        begin
            rec_cnt_reg  <= rec_cnt_reg - CW'(1);
            tomb_cnt_reg <= tomb_cnt_reg + CW'(1);
        end
    end

    // result; index and value latched on the hit cycle
    logic [AW-1:0] hit_idx_reg;
    logic [lpht_pkg::VAL_W-1:0] hit_val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            hit_idx_reg <= '0;
            hit_val_reg <= '0;
        end
        else if (ctl.wr_ins || ctl.wr_tomb)
            hit_idx_reg <= ptr_reg;
        else if (st_rd_reg == lpht_pkg::ST_FULL && key_rd_reg == key_reg &&
                 func_reg == lpht_pkg::FUNC_QUERY && !ctl.rd && !ctl.advance &&
                 !ctl.finish && !ctl.fix_home && !ctl.div_step)
        begin
            hit_idx_reg <= ptr_reg;
            hit_val_reg <= val_rd_reg;
        end
    end

    logic          rv_reg;
    lpht_pkg::rsp_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= ctl.finish;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            res_reg.status       <= ctl.status;
            res_reg.found_value  <= (ctl.status == lpht_pkg::RES_OK &&
                                     func_reg == lpht_pkg::FUNC_QUERY) ? hit_val_reg : '0;
            res_reg.probe_misses <= miss_reg;
            res_reg.slot_index   <= (ctl.status == lpht_pkg::RES_OK) ?
                                    lpht_pkg::IDX_W'(hit_idx_reg) : '0;
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    assign sts.clearing    = clr_reg;
    assign sts.div_done    = (bit_reg == BCW'(KW - 1));
    assign sts.func        = func_reg;
    assign sts.is_full_now = (rec_cnt_reg >= buckets);
    assign sts.slot_st     = st_rd_reg;
    assign sts.key_match   = (key_rd_reg == key_reg);
    assign sts.probes_out  = (miss_reg + CW'(1) >= buckets);

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and tombstones.
// ---------------------------------------------------------------------------
// One item at a time: busy rises the cycle after start is taken and the result
// appears with done for one cycle. probe_misses counts the slots read less
// one, or all slots read when the probe runs out after bucket_count slots.
// A count-refused insert or unknown func reads no slot. busy is low again in
// the done cycle. The serial 32-step modulo and the separate read and evaluate
// states of each slot set the time. After reset busy stays high while the
// slot states clear.
// done cannot be held off; take the result in the cycle it is shown.
`timescale 1ns / 1ps

module linear_probe_hash_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  lpht_pkg::cmd_t              cmd,
    output logic                        done,
    output lpht_pkg::rsp_t              rsp
);

    lpht_pkg::ctl_t ctl;
    lpht_pkg::sts_t sts;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    lpht_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (done),
        .result       (rsp)
    );

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_hash_table. A behavioral copy of the
// table predicts status, value, probe count and slot of every item. Runs a
// directed pass over key extremes and bucket-count limits, then random
// insert/query/remove and unknown-func traffic over several bucket counts with
// key pools built to collide. Each phase ends by draining its records.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = lpht_pkg::TABLE_DEPTH;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [lpht_pkg::CNT_W-1:0] cfg_wdata;
    logic                       start;
    logic                       busy;
    lpht_pkg::cmd_t             cmd;
    logic                       done;
    lpht_pkg::rsp_t             rsp;

    linear_probe_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp)
    );

    // table shadow
    logic [1:0]                 shadow_state [DEPTH];
    logic [lpht_pkg::KEY_W-1:0] shadow_key   [DEPTH];
    logic [lpht_pkg::VAL_W-1:0] shadow_val   [DEPTH];
    int                         live_records;
    int                         tomb_records;
    logic [lpht_pkg::CNT_W-1:0] bucket_reg;

    lpht_pkg::rsp_t             pending_rsp [$];
    int                         errors;
    bit                         quiet;
    logic [lpht_pkg::KEY_W-1:0] key_pool [16];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int buckets_used();
        if (bucket_reg == 0)
            return 1;
        if (bucket_reg > DEPTH)
            return DEPTH;
        return int'(bucket_reg);
    endfunction

    function automatic lpht_pkg::rsp_t apply_op(lpht_pkg::cmd_t c);
        int    b;
        int    p;
        int    misses;
        lpht_pkg::rsp_t r;
        longint kl;
        b = buckets_used();
        r = '0;
        r.status = lpht_pkg::RES_MISSING;
        misses = 0;
        kl = longint'(c.key) % b;
        if (kl < 0)
            kl += b;
        p = int'(kl);
        if (c.func == lpht_pkg::FUNC_INSERT) begin
            r.status = lpht_pkg::RES_FULL;
            if (live_records < b) begin
                while (misses < b) begin
                    if (shadow_state[p] != lpht_pkg::ST_FULL) begin
                        if (shadow_state[p] == lpht_pkg::ST_TOMB)
                            tomb_records--;
                        shadow_state[p] = lpht_pkg::ST_FULL;
                        shadow_key[p]   = c.key;
                        shadow_val[p]   = c.value;
                        live_records++;
                        r.status = lpht_pkg::RES_OK;
                        r.slot_index = p[lpht_pkg::IDX_W-1:0];
                        break;
                    end
                    if (shadow_key[p] == c.key) begin
                        r.status = lpht_pkg::RES_DUP;
                        break;
                    end
                    p = (p + 1 == b) ? 0 : p + 1;
                    misses++;
                end
            end
        end else if (c.func == lpht_pkg::FUNC_QUERY || c.func == lpht_pkg::FUNC_REMOVE) begin
            while (misses < b) begin
                if (shadow_state[p] == lpht_pkg::ST_FULL && shadow_key[p] == c.key) begin
                    r.status = lpht_pkg::RES_OK;
                    r.slot_index = p[lpht_pkg::IDX_W-1:0];
                    if (c.func == lpht_pkg::FUNC_QUERY) begin
                        r.found_value = shadow_val[p];
                    end else begin
                        shadow_state[p] = lpht_pkg::ST_TOMB;
                        tomb_records++;
                        live_records--;
                    end
                    break;
                end
                if (shadow_state[p] == lpht_pkg::ST_EMPTY)
                    break;
                p = (p + 1 == b) ? 0 : p + 1;
                misses++;
            end
        end
        r.probe_misses = misses[lpht_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        lpht_pkg::rsp_t want;
        if (rst_n && done) begin
            if (pending_rsp.size() == 0) begin
                report("unexpected item", 32'(rsp.status), 0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp.status != want.status)
                    report("status", 32'(rsp.status), 32'(want.status));
                if (rsp.found_value != want.found_value)
                    report("found_value", rsp.found_value, want.found_value);
                if (rsp.probe_misses != want.probe_misses)
                    report("probe_misses", 32'(rsp.probe_misses), 32'(want.probe_misses));
                if (rsp.slot_index != want.slot_index)
                    report("slot_index", 32'(rsp.slot_index), 32'(want.slot_index));
            end
        end
    end

    // start stays high across back-to-back items
    task automatic send_item(logic [1:0] f, logic [lpht_pkg::KEY_W-1:0] k,
                             logic [lpht_pkg::VAL_W-1:0] v);
        int   gap;
        lpht_pkg::cmd_t c;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        c.func  = f;
        c.key   = k;
        c.value = v;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_rsp = {pending_rsp, apply_op(c)};
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_buckets(logic [lpht_pkg::CNT_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        bucket_reg = v;
        cfg_we <= 1'b0;
    endtask

    // remove every record reachable under the current bucket count
    task automatic drain_records();
        logic [lpht_pkg::KEY_W-1:0] keys [$];
        int b;
        b = buckets_used();
        for (int i = 0; i < b; i++)
            if (shadow_state[i] == lpht_pkg::ST_FULL)
                keys = {keys, shadow_key[i]};
        foreach (keys[i])
            send_item(lpht_pkg::FUNC_REMOVE, keys[i], $urandom);
    endtask

    task automatic fill_pool();
        logic [lpht_pkg::KEY_W-1:0] base;
        int b;
        b = buckets_used();
        base = $urandom;
        for (int j = 0; j < 16; j++) begin
            if (j < 8)
                key_pool[j] = base + lpht_pkg::KEY_W'(j * b);
            else if (j < 12)
                key_pool[j] = -(base[15:0] + lpht_pkg::KEY_W'(j * b));
            else
                key_pool[j] = $urandom;
        end
        key_pool[15] = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endtask

    task automatic test_key_extremes();
        send_item(lpht_pkg::FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(lpht_pkg::FUNC_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(lpht_pkg::FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_03fd, 32'h1234_5678);
        send_item(lpht_pkg::FUNC_INSERT, 32'h8000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h8000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h7fff_ffff, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_REMOVE, 32'h0000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_03fd, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0000, 32'h0);
        send_item(lpht_pkg::FUNC_REMOVE, 32'h0000_0000, 32'h0);
        send_item(2'd3,                  32'hffff_ffff, 32'hffff_ffff);
        drain_records();
    endtask

    task automatic test_bucket_limits();
        write_buckets('0);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_0005, 32'h5555_aaaa);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_0006, 32'h1);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0006, 32'h0);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0005, 32'h0);
        write_buckets(11'd2);
        send_item(lpht_pkg::FUNC_INSERT, 32'hffff_fffe, 32'h2);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_0004, 32'h3);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0007, 32'h0);
        drain_records();
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_0007, 32'h0);
        write_buckets(11'h7ff);
        send_item(lpht_pkg::FUNC_INSERT, 32'h0000_03ff, 32'h9);
        send_item(lpht_pkg::FUNC_QUERY,  32'h0000_03ff, 32'h0);
        drain_records();
    endtask

    task automatic test_random_traffic();
        logic [lpht_pkg::CNT_W-1:0] settings [11];
        int  roll;
        logic [1:0] f;
        logic [lpht_pkg::KEY_W-1:0] k;
        settings = '{11'd7, 11'd1, 11'd13, 11'd2, 11'd1024, 11'd1021, 11'd0,
                     11'd97, 11'd31, 11'h7ff, 11'd3};
        foreach (settings[s]) begin
            write_buckets(settings[s]);
            fill_pool();
            quiet = (s % 3 == 1);
            for (int i = 0; i < 87; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    f = lpht_pkg::FUNC_INSERT;
                else if (roll < 75)
                    f = lpht_pkg::FUNC_QUERY;
                else if (roll < 95)
                    f = lpht_pkg::FUNC_REMOVE;
                else
                    f = 2'd3;
                k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
                send_item(f, k, $urandom);
            end
            quiet = 1'b0;
            drain_records();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        start     = 1'b0;
        cmd       = '0;
        errors    = 0;
        quiet     = 1'b0;
        live_records = 0;
        tomb_records = 0;
        bucket_reg   = 11'd1021;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_state[i] = lpht_pkg::ST_EMPTY;
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_extremes();
        test_bucket_limits();
        test_random_traffic();

        wait_idle();
        repeat (2200) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
